@@ design/pcsp_pkg.sv @@
package pcsp_pkg;

    localparam int unsigned SAMPLE_W   = 32;
    localparam int unsigned MODE_W     = 4;
    localparam int unsigned BITS_W     = 6;
    localparam int unsigned SH_W       = 5;
    localparam int unsigned MAX_SH     = 23;
    localparam int unsigned PROD_W     = SAMPLE_W + MAX_SH;
    localparam int unsigned QC_W       = 24;
    localparam int unsigned ACC_W      = 40;
    localparam int unsigned HELD_W     = 6;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned NB_W       = 3;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = 2;
    localparam int unsigned CNT_W      = 3;

    localparam logic [MODE_W-1:0] MODE_1B  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_3B  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_4B  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_8B  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_10B = 4'd4;
    localparam logic [MODE_W-1:0] MODE_12B = 4'd5;
    localparam logic [MODE_W-1:0] MODE_16B = 4'd6;
    localparam logic [MODE_W-1:0] MODE_24B = 4'd7;
    localparam logic [MODE_W-1:0] MODE_32B = 4'd8;
    localparam logic [MODE_W-1:0] DEPTH_RST = MODE_16B;

    typedef struct packed {
        logic              vld;
        logic [BITS_W-1:0] nbits;
        logic [POS_W-1:0]  grp_len;
        logic [NB_W-1:0]   grp_bytes;
        logic              rnd;
    } t_mode_info;

    // One finished group on its way to the byte serializer.
    typedef struct packed {
        logic [ACC_W-1:0] data;
        logic [NB_W-1:0]  nbytes;
        logic             last;
    } t_group;

    function automatic t_mode_info mk_info(input logic [BITS_W-1:0] nbits,
                                           input logic [POS_W-1:0] grp_len,
                                           input logic [NB_W-1:0] grp_bytes,
                                           input logic rnd);
        t_mode_info mi;
        mi.vld       = 1'b1;
        mi.nbits     = nbits;
        mi.grp_len   = grp_len;
        mi.grp_bytes = grp_bytes;
        mi.rnd       = rnd;
        return mi;
    endfunction

    function automatic t_mode_info mode_info(input logic [MODE_W-1:0] mode);
        t_mode_info mi;
        unique case (mode)
            MODE_1B:  mi = mk_info(6'd1,  4'd8, 3'd1, 1'b0);
            MODE_3B:  mi = mk_info(6'd3,  4'd2, 3'd1, 1'b1);
            MODE_4B:  mi = mk_info(6'd4,  4'd2, 3'd1, 1'b1);
            MODE_8B:  mi = mk_info(6'd8,  4'd1, 3'd1, 1'b1);
            MODE_10B: mi = mk_info(6'd10, 4'd4, 3'd5, 1'b1);
            MODE_12B: mi = mk_info(6'd12, 4'd2, 3'd3, 1'b0);
            MODE_16B: mi = mk_info(6'd16, 4'd1, 3'd2, 1'b0);
            MODE_24B: mi = mk_info(6'd24, 4'd1, 3'd3, 1'b0);
            MODE_32B: mi = mk_info(6'd32, 4'd1, 3'd4, 1'b0);
            default:  mi = '0;
        endcase
        return mi;
    endfunction

endpackage

@@ design/pcsp_front.sv @@
module pcsp_front #(
    parameter int unsigned FRACTION_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [3:0]             i_cfg_data,
    input  logic                   i_s_vld,
    input  logic [31:0]            i_sample,
    input  logic                   i_final,
    output logic                   o_ready,
    output logic                   o_push,
    output pcsp_pkg::t_group       o_push_data,
    input  logic                   i_full
);

    localparam int unsigned PW  = pcsp_pkg::PROD_W;
    localparam int unsigned SW  = pcsp_pkg::SAMPLE_W;
    localparam int unsigned AW  = pcsp_pkg::ACC_W;
    localparam int unsigned QCW = pcsp_pkg::QC_W;
    localparam int unsigned SHW = pcsp_pkg::SH_W;
    localparam int unsigned HW  = pcsp_pkg::HELD_W;
    localparam int unsigned PSW = pcsp_pkg::POS_W;
    localparam int unsigned QW  = PW - FRACTION_BITS;
    localparam logic [PW-1:0] RND_ADD = PW'(1) << (FRACTION_BITS - 1);

    logic [pcsp_pkg::MODE_W-1:0] r_depth;
    pcsp_pkg::t_mode_info        mi;
    logic                        adv;
    logic [SHW-1:0]              sh;

    logic          r_s1_vld, r_s1_neg, r_s1_last;
    logic [SW-1:0] r_s1_mag, r_s1_raw;
    logic          r_s2_vld, r_s2_neg, r_s2_last;
    logic [SW-1:0] r_s2_raw;
    logic [PW-1:0] r_s2_prod;
    logic          r_s3_vld, r_s3_last;
    logic [SW-1:0] r_s3_code;

    logic [AW-1:0]  r_acc;
    logic [HW-1:0]  r_held;
    logic [PSW-1:0] r_pos;

    logic [PW-1:0]  n_prod;
    logic [PW-1:0]  sum;
    logic [QW-1:0]  q;
    logic [QCW:0]   half;
    logic [QCW-1:0] lim, qc;
    logic [SW-1:0]  mask, code_q, n_code;
    logic [AW-1:0]  n_acc;
    logic [PSW-1:0] n_pos;
    logic           done;

    assign mi      = pcsp_pkg::mode_info(r_depth);
    assign adv     = !i_full;
    assign o_ready = adv;
    assign sh      = SHW'(mi.nbits - 6'd1);

    // Scale by 2^(n-1)-1 as a shift and a subtract.
    assign n_prod = ({{(PW - SW){1'b0}}, r_s1_mag} << sh) - {{(PW - SW){1'b0}}, r_s1_mag};

    // Round where the mode asks for it, drop the fraction, clamp to the code range, then negate back.
    assign sum    = r_s2_prod + (mi.rnd ? RND_ADD : '0);
    assign q      = sum[PW-1:FRACTION_BITS];
    assign half   = {{QCW{1'b0}}, 1'b1} << sh;
    assign lim    = r_s2_neg ? half[QCW-1:0] : QCW'(half - 1'b1);
    assign qc     = (q > QW'(lim)) ? lim : q[QCW-1:0];
    assign mask   = (SW'(1) << mi.nbits) - SW'(1);
    assign code_q = (r_s2_neg ? (SW'(0) - SW'(qc)) : SW'(qc)) & mask;

    always_comb begin
        if (r_depth == pcsp_pkg::MODE_1B) begin
            n_code = {{(SW - 1){1'b0}}, (!r_s2_raw[SW-1] && (|r_s2_raw))};
        end else if (r_depth == pcsp_pkg::MODE_32B) begin
            n_code = r_s2_raw;
        end else begin
            n_code = code_q;
        end
    end

    assign n_acc = r_acc | (AW'(r_s3_code) << r_held);
    assign n_pos = r_pos + 1'b1;
    assign done  = (n_pos == mi.grp_len) || r_s3_last;

    assign o_push             = r_s3_vld && adv && done;
    assign o_push_data.data   = n_acc;
    assign o_push_data.nbytes = mi.grp_bytes;
    assign o_push_data.last   = r_s3_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            // Beats in an undefined depth mode are taken and dropped.
            r_s1_vld <= i_s_vld && mi.vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_neg  <= i_sample[SW-1];
            r_s1_mag  <= i_sample[SW-1] ? (~i_sample + SW'(1)) : i_sample;
            r_s1_raw  <= i_sample;
            r_s1_last <= i_final;
            r_s2_neg  <= r_s1_neg;
            r_s2_raw  <= r_s1_raw;
            r_s2_last <= r_s1_last;
            r_s2_prod <= n_prod;
            r_s3_code <= n_code;
            r_s3_last <= r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= pcsp_pkg::DEPTH_RST;
            r_acc   <= '0;
            r_held  <= '0;
            r_pos   <= '0;
        end else if (i_cfg_valid) begin
            r_depth <= i_cfg_data;
            r_acc   <= '0;
            r_held  <= '0;
            r_pos   <= '0;
        end else if (r_s3_vld && adv) begin
            if (done) begin
                r_acc  <= '0;
                r_held <= '0;
                r_pos  <= '0;
            end else begin
                r_acc  <= n_acc;
                r_held <= r_held + mi.nbits;
                r_pos  <= n_pos;
            end
        end
    end

endmodule

@@ design/pcsp_fifo.sv @@
module pcsp_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pcsp_pkg::t_group i_push_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output pcsp_pkg::t_group o_head
);

    localparam int unsigned DEPTH = pcsp_pkg::FIFO_DEPTH;
    localparam int unsigned PW    = pcsp_pkg::PTR_W;
    localparam int unsigned CW    = pcsp_pkg::CNT_W;

    pcsp_pkg::t_group r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("group queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("group queue read while empty");
`endif

endmodule

@@ design/pcsp_back.sv @@
module pcsp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  pcsp_pkg::t_group i_head,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast
);

    localparam int unsigned AW = pcsp_pkg::ACC_W;
    localparam int unsigned NW = pcsp_pkg::NB_W;

    logic          r_valid;
    logic [NW-1:0] r_left;
    logic [AW-1:0] r_data;
    logic          r_last;
    logic          take, more, load;

    assign take = r_valid && i_m_tready;
    assign more = (r_left > NW'(1));
    // Pull the next group when idle or when the last byte of this one leaves.
    assign load = !i_empty && (!r_valid || (take && !more));

    assign o_pop      = load;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data[7:0];
    assign o_m_tlast  = r_valid && r_last && (r_left == NW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_left  <= i_head.nbytes;
        end else if (take) begin
            if (more) begin
                r_left <= r_left - 1'b1;
            end else begin
                r_valid <= 1'b0;
                r_left  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_head.data;
            r_last <= i_head.last;
        end else if (take && more) begin
            r_data <= r_data >> 8;
        end
    end

`ifndef SYNTHESIS
    a_valid_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_left != '0))
        else $error("output valid with no bytes left");
    a_group_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && more) |=> r_valid)
        else $error("group dropped before its last byte");
    a_tlast_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tlast && !i_m_tready) |=> o_m_tlast)
        else $error("last-byte marker lost while stalled");
`endif

endmodule

@@ design/pcm_sample_packer.sv @@
// A group's closing beat passes quantizer stages s1, s2 and s3, is written to the
// group queue and is then loaded into the serializer's output register. One sample
// is taken per cycle while the group queue is not full; the byte serializer sends
// one byte per cycle while the output is ready.
// A four-entry group queue sits between the quantizer pipeline and the serializer.
// Reset (synchronous, active low) selects 16-bit depth and clears all group state.
module pcm_sample_packer #(
    parameter int unsigned FRACTION_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,        // depth_mode
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,    // [31:0] sample
    input  logic        i_s_axis_tlast,    // final_sample
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,    // [7:0] packed_byte
    output logic        o_m_axis_tlast     // final_byte
);

    logic             push, pop, full, empty;
    pcsp_pkg::t_group push_data, head;

    assign o_cfg_ready = 1'b1;

    pcsp_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_vld     (i_s_axis_tvalid),
        .i_sample    (i_s_axis_tdata),
        .i_final     (i_s_axis_tlast),
        .o_ready     (o_s_axis_tready),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    pcsp_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_full      (full),
        .o_empty     (empty),
        .o_head      (head)
    );

    pcsp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule
